/* hw/rtl/lce_pkg.sv */
// ----------------------------------------------------------------------------
// lce_pkg
// Shared widths, status codes, controller state and control/status bundles
// for the LIS count engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lce_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;

    localparam int VALUE_W  = 32;
    localparam int LEN_W    = 11;
    localparam int COUNT_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [LEN_W-1:0]   LEN_CAP   = {LEN_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_EMIT
    } lce_state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;     // input channel ready
        logic load;     // latch new element, start scan
        logic drop;     // element beyond capacity
        logic scan;     // scan in progress
        logic commit;   // store element, update best
        logic emit;     // load result register, clear sequence
    } lce_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic full;
        logic scan_done;
        logic last_held;
        logic out_free;
    } lce_stat_t;

    // Saturating add; MSB of the result flags a clipped sum.
    function automatic logic [COUNT_W:0] sat_add(
        input logic [COUNT_W-1:0] a,
        input logic [COUNT_W-1:0] b
    );
        logic [COUNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum[COUNT_W])
            return {1'b1, COUNT_MAX};
        return sum;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lce_item_if.sv */
// ----------------------------------------------------------------------------
// lce_item_if
// Element request channel: valid/ready with value and last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface lce_item_if;
    import lce_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lce_result_if.sv */
// ----------------------------------------------------------------------------
// lce_result_if
// Result request channel: valid/ready with count, length and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface lce_result_if;
    import lce_pkg::*;

    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  lis_count;
    logic [LEN_W-1:0]    lis_length;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output lis_count, output lis_length, output status,
                    input ready);
    modport sink   (input valid, input lis_count, input lis_length, input status,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/lce_ctrl.sv */
// ----------------------------------------------------------------------------
// lce_ctrl
// Sequencer: accept element, scan stored elements, commit, emit result.
// ----------------------------------------------------------------------------
`default_nettype none

module lce_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  lce_pkg::lce_stat_t  stat,
    output lce_pkg::lce_cmd_t   cmd
);
    import lce_pkg::*;

    lce_state_t state_reg;
    lce_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.in_valid)
                begin
                    if (!stat.full)
                        state_next = ST_SCAN;
                    else if (stat.in_last)
                        state_next = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = stat.last_held ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                cmd.load = stat.in_valid && !stat.full;
                cmd.drop = stat.in_valid && stat.full;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/lce_datapath.sv */
// ----------------------------------------------------------------------------
// lce_datapath
// Element store, scan accumulator, running best, flags and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lce_datapath #(
    parameter int MAX_ELEMENTS = lce_pkg::MAX_ELEMENTS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  lce_pkg::lce_cmd_t   cmd,
    output lce_pkg::lce_stat_t  stat,
    lce_item_if.sink            item,
    lce_result_if.source        result
);
    import lce_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ELEMENTS);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   len;
        logic [COUNT_W-1:0] count;
    } lce_entry_t;

    lce_entry_t store_mem [MAX_ELEMENTS];

    // control state
    logic [CW-1:0]       items_reg,    items_next;
    logic [CW-1:0]       rd_addr_reg,  rd_addr_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                last_reg,     last_next;
    logic [LEN_W-1:0]    best_len_reg, best_len_next;
    logic [COUNT_W-1:0]  best_cnt_reg, best_cnt_next;
    logic                sat_reg,      sat_next;
    logic                drop_reg,     drop_next;
    logic                out_valid_reg, out_valid_next;

    // payload
    logic [VALUE_W-1:0]  key_reg;
    lce_entry_t          rdata_reg;
    logic [LEN_W-1:0]    acc_len_reg,  acc_len_next;
    logic [COUNT_W-1:0]  acc_cnt_reg,  acc_cnt_next;
    logic [COUNT_W-1:0]  out_cnt_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                rd_en;
    logic                hit;
    logic [LEN_W-1:0]    cand;
    logic [COUNT_W:0]    acc_sum;
    logic [COUNT_W:0]    best_sum;

    assign rd_en = cmd.scan && (rd_addr_reg != items_reg);

    assign stat.in_valid  = item.valid;
    assign stat.in_last   = item.last;
    assign stat.full      = (items_reg == FULL_CNT);
    assign stat.scan_done = (rd_addr_reg == items_reg);
    assign stat.last_held = last_reg;
    assign stat.out_free  = !out_valid_reg || result.ready;

    assign item.ready        = cmd.take;
    assign result.valid      = out_valid_reg;
    assign result.lis_count  = out_cnt_reg;
    assign result.lis_length = out_len_reg;
    assign result.status     = out_status_reg;

    // scan step on the registered read
    assign hit     = $signed(rdata_reg.value) < $signed(key_reg);
    assign cand    = (rdata_reg.len == LEN_CAP) ? LEN_CAP : rdata_reg.len + 1'b1;
    assign acc_sum = sat_add(acc_cnt_reg, rdata_reg.count);

    // commit step
    assign best_sum = sat_add(best_cnt_reg, acc_cnt_reg);

    always_comb
    begin
        items_next     = items_reg;
        rd_addr_next   = rd_addr_reg;
        rd_valid_next  = rd_en;
        last_next      = last_reg;
        best_len_next  = best_len_reg;
        best_cnt_next  = best_cnt_reg;
        sat_next       = sat_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg;
        acc_len_next   = acc_len_reg;
        acc_cnt_next   = acc_cnt_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        if (cmd.load || cmd.drop)
            last_next = item.last;

        if (cmd.drop)
            drop_next = 1'b1;

        if (cmd.load)
        begin
            rd_addr_next = '0;
            acc_len_next = LEN_W'(1);
            acc_cnt_next = COUNT_W'(1);
        end

        if (rd_en)
            rd_addr_next = rd_addr_reg + 1'b1;

        if (rd_valid_reg && hit)
        begin
            if (cand > acc_len_reg)
            begin
                acc_len_next = cand;
                acc_cnt_next = rdata_reg.count;
            end
            else if (cand == acc_len_reg)
            begin
                acc_cnt_next = acc_sum[COUNT_W-1:0];
                if (acc_sum[COUNT_W])
                    sat_next = 1'b1;
            end
        end

        if (cmd.commit)
        begin
            items_next = items_reg + 1'b1;
            if (acc_len_reg > best_len_reg)
            begin
                best_len_next = acc_len_reg;
                best_cnt_next = acc_cnt_reg;
            end
            else if (acc_len_reg == best_len_reg)
            begin
                best_cnt_next = best_sum[COUNT_W-1:0];
                if (best_sum[COUNT_W])
                    sat_next = 1'b1;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            items_next     = '0;
            best_len_next  = '0;
            best_cnt_next  = '0;
            sat_next       = 1'b0;
            drop_next      = 1'b0;
            last_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_reg     <= '0;
            rd_addr_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            last_reg      <= 1'b0;
            best_len_reg  <= '0;
            best_cnt_reg  <= '0;
            sat_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            items_reg     <= items_next;
            rd_addr_reg   <= rd_addr_next;
            rd_valid_reg  <= rd_valid_next;
            last_reg      <= last_next;
            best_len_reg  <= best_len_next;
            best_cnt_reg  <= best_cnt_next;
            sat_reg       <= sat_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_len_reg <= acc_len_next;
        acc_cnt_reg <= acc_cnt_next;
        if (cmd.load)
            key_reg <= item.value;
        if (cmd.emit)
        begin
            out_cnt_reg    <= best_cnt_reg;
            out_len_reg    <= best_len_reg;
            out_status_reg <= drop_reg ? STATUS_DROP : (sat_reg ? STATUS_SAT : STATUS_OK);
        end
    end

    // element store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            store_mem[items_reg[AW-1:0]] <= '{value: key_reg, len: acc_len_reg,
                                              count: acc_cnt_reg};
        if (rd_en)
            rdata_reg <= store_mem[rd_addr_reg[AW-1:0]];
    end

endmodule

`default_nettype wire

/* hw/rtl/lis_count_engine.sv */
// ----------------------------------------------------------------------------
// lis_count_engine
// Length and number of longest strictly increasing subsequences of a
// sequence of signed 32-bit elements.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | request moves
//  item    | in  | value[31:0] signed, last         | one sequence element
//  result  | out | lis_count[31:0], lis_length[10:0],| one result per sequence
//          |     | status[1:0]                      |
//
//  From accept to next ready, an element goes through one read of the element
//  store per stored element through its single read port, the registered
//  read and a commit. A last element then loads the result register, which
//  waits while a previous result is still held.
//  Elements beyond capacity are accepted without a scan and dropped.
//  Reset is asynchronous; the store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_count_engine #(
    parameter int MAX_ELEMENTS = lce_pkg::MAX_ELEMENTS_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    lce_item_if.sink      item,
    lce_result_if.source  result
);
    import lce_pkg::*;

    lce_cmd_t  cmd;
    lce_stat_t stat;

    lce_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    lce_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .item   (item),
        .result (result)
    );

endmodule

`default_nettype wire

/* hw/rtl/lce_checker.sv */
// ----------------------------------------------------------------------------
// lce_checker
// Port-level checks on the LIS count engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lce_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           res_valid,
    input wire                           res_ready,
    input wire [lce_pkg::COUNT_W-1:0]    res_count,
    input wire [lce_pkg::LEN_W-1:0]      res_length,
    input wire [lce_pkg::STATUS_W-1:0]   res_status
);
    import lce_pkg::*;

    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_count)
            && $stable(res_length) && $stable(res_status))
        else $error("result changed while stalled");

    // every sequence has at least one stored element or was a drop
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_length == '0 |-> res_status == STATUS_DROP)
        else $error("empty length without drop status");

    // a nonzero length always has at least one subsequence
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_length != '0 |-> res_count != '0)
        else $error("zero count for nonzero length");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_status == STATUS_OK || res_status == STATUS_SAT
            || res_status == STATUS_DROP)
        else $error("undefined status code");

endmodule

bind lis_count_engine lce_checker u_lce_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_count  (result.lis_count),
    .res_length (result.lis_length),
    .res_status (result.status)
);

`default_nettype wire

/* test/lis_count_engine_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_count_engine_check
// Watches both channels of the LIS count engine. Every accepted element
// request updates a local model of the stored sequence. A last element queues
// the expected length, count and status. Every accepted result request is
// compared with the oldest queued one.
// ----------------------------------------------------------------------------
module lis_count_engine_check (
    input  wire   clk,
    input  wire   rst_n,
    lce_item_if   item,
    lce_result_if result,
    output int    errors,
    output int    pending
);
    import lce_pkg::*;

    localparam int DEPTH = MAX_ELEMENTS_DEF;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [LEN_W-1:0]    length;
        logic [STATUS_W-1:0] status;
    } lis_summary_t;

    logic signed [VALUE_W-1:0] elem_value [DEPTH];
    logic [LEN_W-1:0]          elem_length [DEPTH];
    logic [COUNT_W-1:0]        elem_count [DEPTH];

    int unsigned        stored;
    logic [LEN_W-1:0]   best_len;
    logic [COUNT_W-1:0] best_cnt;
    logic               clipped;
    logic               dropped;

    lis_summary_t summary_q[$];

    // carry-out in the MSB; a clipped sum reads as all ones
    function automatic logic [COUNT_W:0] clip_sum(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[COUNT_W])
            s = {1'b1, COUNT_MAX};
        return s;
    endfunction

    task automatic clear_sequence();
        stored   = 0;
        best_len = '0;
        best_cnt = '0;
        clipped  = 1'b0;
        dropped  = 1'b0;
    endtask

    task automatic absorb_element(input logic signed [VALUE_W-1:0] v, input logic is_last);
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   cand;
        logic [COUNT_W-1:0] cnt;
        logic [COUNT_W:0]   s;
        lis_summary_t       res;
        if (stored < DEPTH) begin
            len = LEN_W'(1);
            cnt = COUNT_W'(1);
            for (int i = 0; i < stored; i++) begin
                if (elem_value[i] < v) begin
                    cand = (elem_length[i] == LEN_CAP) ? LEN_CAP : elem_length[i] + 1'b1;
                    if (cand > len) begin
                        len = cand;
                        cnt = elem_count[i];
                    end
                    else if (cand == len) begin
                        s = clip_sum(cnt, elem_count[i]);
                        clipped = clipped | s[COUNT_W];
                        cnt = s[COUNT_W-1:0];
                    end
                end
            end
            elem_value[stored]  = v;
            elem_length[stored] = len;
            elem_count[stored]  = cnt;
            stored++;
            if (len > best_len) begin
                best_len = len;
                best_cnt = cnt;
            end
            else if (len == best_len) begin
                s = clip_sum(best_cnt, cnt);
                clipped = clipped | s[COUNT_W];
                best_cnt = s[COUNT_W-1:0];
            end
        end
        else begin
            dropped = 1'b1;
        end
        if (is_last) begin
            res.count  = best_cnt;
            res.length = best_len;
            res.status = dropped ? STATUS_DROP : (clipped ? STATUS_SAT : STATUS_OK);
            summary_q.push_back(res);
            clear_sequence();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        lis_summary_t want;
        if (!rst_n) begin
            clear_sequence();
            summary_q.delete();
            errors  = 0;
            pending <= 0;
        end
        else begin
            if (result.valid && result.ready) begin
                if (summary_q.size() == 0) begin
                    $error("result with none outstanding: lis_count %0d lis_length %0d status %0d",
                           result.lis_count, result.lis_length, result.status);
                    errors++;
                end
                else begin
                    want = summary_q.pop_front();
                    if (result.lis_count !== want.count) begin
                        $error("lis_count: expected %0d, got %0d", want.count, result.lis_count);
                        errors++;
                    end
                    if (result.lis_length !== want.length) begin
                        $error("lis_length: expected %0d, got %0d", want.length,
                               result.lis_length);
                        errors++;
                    end
                    if (result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        errors++;
                    end
                end
            end
            if (item.valid && item.ready)
                absorb_element(item.value, item.last);
            pending <= summary_q.size();
        end
    end

endmodule

/* test/lis_count_engine_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_count_engine_test
// Drives element sequences into the LIS count engine: directed corner cases,
// a count-saturating layered sequence, one sequence past capacity and random
// sequences, with random gaps on the element channel and random back-pressure on
// the result channel. Checking is done by lis_count_engine_check; this module gives the verdict.
// ----------------------------------------------------------------------------
module lis_count_engine_test;
    import lce_pkg::*;

    localparam int RANDOM_ELEMENTS = 580;
    localparam int LONG_HOLD       = 600;

    logic clk = 1'b0;
    logic rst_n;

    int errors;
    int pending;
    int elements_sent;
    int sequences_sent;
    bit burst;

    lce_item_if   item_ch ();
    lce_result_if result_ch ();

    lis_count_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    lis_count_engine_check u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom();
        if (r < 8)
            return $urandom_range(0, 16) - 8;
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h8000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return 32'h0000_0001;
            5: return 32'h7FFF_FFFE;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // valid stays high across back-to-back requests
    task automatic push_element(input logic [VALUE_W-1:0] v, input logic is_last);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.value <= v;
        item_ch.last  <= is_last;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        elements_sent++;
    endtask

    task automatic send_sequence(input logic [VALUE_W-1:0] vals[$]);
        for (int i = 0; i < vals.size(); i++)
            push_element(vals[i], i == vals.size() - 1);
        sequences_sent++;
    endtask

    // Blocks of non-increasing values, each block above the previous one:
    // the count multiplies by the block width at every level.
    task automatic send_layers(input int levels, input int width);
        logic [VALUE_W-1:0] vals[$];
        logic [VALUE_W-1:0] v;
        for (int b = 0; b < levels; b++) begin
            v = 32'h8000_0000 + (b + 1) * 32'h0200_0000 - 1;
            for (int j = 0; j < width; j++) begin
                v = v - $urandom_range(0, 32'h0004_0000);
                vals.push_back(v);
            end
        end
        send_sequence(vals);
    endtask

    // 34 descending pairs saturate the count, the rest climbs to capacity,
    // then two more elements are dropped.
    task automatic send_past_capacity();
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] v;
        base = 32'h8000_0000 + $urandom_range(0, 1000);
        for (int k = 0; k < 34; k++) begin
            push_element(base + 2 * k + 1, 1'b0);
            push_element(base + 2 * k, 1'b0);
        end
        v = base + 68;
        for (int i = 68; i < MAX_ELEMENTS_DEF; i++) begin
            push_element(v, 1'b0);
            v = v + $urandom_range(1, 3);
        end
        push_element(pick_value(), 1'b0);
        push_element(pick_value(), 1'b1);
        sequences_sent++;
    endtask

    task automatic send_random_sequence();
        logic [VALUE_W-1:0] vals[$];
        logic [VALUE_W-1:0] v;
        int kind;
        int n;
        kind  = $urandom_range(0, 99);
        burst = ($urandom_range(0, 4) == 0);
        if (kind < 45 || kind >= 80) begin
            n = (kind < 45) ? $urandom_range(1, 16) : $urandom_range(17, 40);
            repeat (n) vals.push_back(pick_value());
            send_sequence(vals);
        end
        else if (kind < 65) begin
            n = $urandom_range(2, 24);
            v = pick_value();
            repeat (n) begin
                vals.push_back(v);
                v = v + $urandom_range(0, 5) - 1;
            end
            send_sequence(vals);
        end
        else begin
            send_layers($urandom_range(2, 24), $urandom_range(1, 4));
        end
        burst = 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // result side: random ready, one long hold-off once results are flowing
    initial
    begin
        int taken;
        int span;
        int r;
        bit held;
        logic lvl;
        taken = 0;
        held  = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (!held && taken >= 20) begin
                held = 1'b1;
                lvl  = 1'b0;
                span = LONG_HOLD;
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    lvl  = 1'b1;
                    span = $urandom_range(1, 24);
                end
                else begin
                    lvl  = 1'b0;
                    if (r < 88)
                        span = $urandom_range(1, 3);
                    else if (r < 97)
                        span = $urandom_range(4, 16);
                    else
                        span = $urandom_range(30, 120);
                end
            end
            result_ch.ready <= lvl;
            repeat (span) begin
                @(posedge clk);
                if (result_ch.valid && result_ch.ready)
                    taken++;
            end
        end
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int random_start;
        elements_sent  = 0;
        sequences_sent = 0;
        burst          = 1'b0;
        rst_n          <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.value  <= '0;
        item_ch.last   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, ties, decreasing runs and a two-way tie for the best length
        send_sequence('{32'h8000_0000});
        send_sequence('{32'h7FFF_FFFF});
        send_sequence('{32'h7FFF_FFFF, 32'h8000_0000});
        send_sequence('{32'h8000_0000, 32'h7FFF_FFFF});
        send_sequence('{32'd5, 32'd5, 32'd5});
        send_sequence('{32'd1, 32'd3, 32'd5, 32'd4, 32'd7});
        send_sequence('{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1});
        send_sequence('{32'd3, 32'd2, 32'd1});

        send_layers(34, 2);

        random_start = elements_sent;
        while (elements_sent - random_start < RANDOM_ELEMENTS / 2)
            send_random_sequence();

        // sender goes quiet until every outstanding result is back
        item_ch.valid <= 1'b0;
        wait_drained();
        send_past_capacity();

        random_start = random_start + (elements_sent - random_start);
        while (elements_sent - random_start < RANDOM_ELEMENTS - RANDOM_ELEMENTS / 2)
            send_random_sequence();

        @(posedge clk);
        item_ch.valid <= 1'b0;
        wait_drained();
        repeat (50) @(posedge clk);

        $display("Ran %0d sequences, %0d element requests: corner values, ties, saturation,",
                 sequences_sent, elements_sent);
        $display("a sequence past capacity, long result back-pressure and a full drain.");
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* lis_count_engine.f */
hw/rtl/lce_pkg.sv
hw/rtl/lce_item_if.sv
hw/rtl/lce_result_if.sv
hw/rtl/lce_ctrl.sv
hw/rtl/lce_datapath.sv
hw/rtl/lis_count_engine.sv
hw/rtl/lce_checker.sv
test/lis_count_engine_check.sv
test/lis_count_engine_test.sv
